@@ src/azse_pkg.sv @@
// ----------------------------------------------------------------------------
// Zero-sequence frame encoder package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package azse_pkg;

    // Field widths of one subframe and of one output word.
    localparam int DATA_W = 36;
    localparam int WORD_W = 37;
    localparam int HDR_W  = 24;

    // Zero runs: eight bits long, starting at positions 0 to 28, at most four.
    localparam int RUN_LEN        = 8;
    localparam int LAST_RUN_START = 28;
    localparam int NUM_STARTS     = LAST_RUN_START + 1;
    localparam int MAX_RUNS       = 4;
    localparam int POS_W          = 5;
    localparam int RUN_CNT_W      = 3;

    // Subframe position within a frame of eight.
    localparam int SUB_IDX_W = 3;
    localparam logic [SUB_IDX_W-1:0] FIRST_SUB = 3'd0;
    localparam logic [SUB_IDX_W-1:0] LAST_SUB  = 3'd7;

    // Header bits that follow the sixteen zeros: the one, then C1, C2 and C3.
    localparam logic [3:0] HDR_LEAD = 4'b1011;

    typedef logic [POS_W-1:0] run_pos_t;

    // One classified subframe as it waits between the front and back ends.
    typedef struct packed {
        logic [DATA_W-1:0]                data;
        run_pos_t [MAX_RUNS-1:0]          runs;
        logic [RUN_CNT_W-1:0]             run_count;
        logic [1:0]                       m;
        logic                             c4;
        logic                             c5;
        logic                             first;
        logic                             last;
    } item_t;

endpackage

@@ src/azse_front.sv @@
// ----------------------------------------------------------------------------
// Zero-sequence frame encoder front end
// Accepts subframes, tracks the frame position and finds the zero runs.
// ----------------------------------------------------------------------------
module azse_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [azse_pkg::DATA_W-1:0]   data_bits,
    input  logic [1:0]                    m_bits,
    input  logic                          c4_bit,
    input  logic                          c5_bit,
    input  logic                          subframe_valid,
    output logic                          subframe_stall,
    input  logic                          q_full,
    output logic                          push,
    output azse_pkg::item_t               push_item
);

    localparam logic [azse_pkg::NUM_STARTS-1:0] RUN_MASK =
        azse_pkg::NUM_STARTS'((1 << azse_pkg::RUN_LEN) - 1);

    logic [azse_pkg::SUB_IDX_W-1:0]  sub_idx_reg;
    logic [azse_pkg::SUB_IDX_W-1:0]  sub_idx_next;
    logic [azse_pkg::NUM_STARTS-1:0] zero_at;
    logic [azse_pkg::NUM_STARTS-1:0] avail;
    azse_pkg::run_pos_t              pos;
    logic                            hit;
    azse_pkg::run_pos_t [azse_pkg::MAX_RUNS-1:0] runs;
    logic [azse_pkg::RUN_CNT_W-1:0]  run_count;

    // The queue takes an item whenever it has room.
    assign subframe_stall = q_full;
    assign push           = subframe_valid && !q_full;

    // One flag per start position: eight zero bits begin there.
    always_comb
    begin
        for (int p = 0; p < azse_pkg::NUM_STARTS; p++)
        begin
            zero_at[p] = ~|data_bits[azse_pkg::DATA_W-1-p -: azse_pkg::RUN_LEN];
        end
    end

    // Greedy run selection: take the lowest free start, then block the
    // seven starts that would overlap it, up to four times.
    always_comb
    begin
        avail     = zero_at;
        run_count = '0;
        runs      = '0;
        pos       = '0;
        hit       = 1'b0;
        for (int k = 0; k < azse_pkg::MAX_RUNS; k++)
        begin
            hit = 1'b0;
            pos = '0;
            for (int p = azse_pkg::NUM_STARTS - 1; p >= 0; p--)
            begin
                if (avail[p])
                begin
                    hit = 1'b1;
                    pos = azse_pkg::POS_W'(p);
                end
            end
            if (hit)
            begin
                runs[k]   = pos;
                run_count = run_count + 1'b1;
                avail     = avail & ~(RUN_MASK << pos);
            end
        end
    end

    // Item handed to the queue.
    always_comb
    begin
        push_item.data      = data_bits;
        push_item.runs      = runs;
        push_item.run_count = run_count;
        push_item.m         = m_bits;
        push_item.c4        = c4_bit;
        push_item.c5        = c5_bit;
        push_item.first     = (sub_idx_reg == azse_pkg::FIRST_SUB);
        push_item.last      = (sub_idx_reg == azse_pkg::LAST_SUB);
    end

    // Subframe counter, wrapping after the eighth subframe.
    always_comb
    begin
        sub_idx_next = sub_idx_reg;
        if (push)
        begin
            sub_idx_next = sub_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_idx_reg <= '0;
        end
        else
        begin
            sub_idx_reg <= sub_idx_next;
        end
    end

endmodule

@@ src/azse_queue.sv @@
// ----------------------------------------------------------------------------
// Zero-sequence frame encoder queue
// Short first-in first-out buffer of classified items between the two ends.
// ----------------------------------------------------------------------------
module azse_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  azse_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output azse_pkg::item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    azse_pkg::item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/azse_back.sv @@
// ----------------------------------------------------------------------------
// Zero-sequence frame encoder back end
// Builds the header and the encoded subframe and drives the output register.
// ----------------------------------------------------------------------------
module azse_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  azse_pkg::item_t               head_item,
    output logic                          pop,
    output logic                          word_valid,
    input  logic                          word_stall,
    output logic [azse_pkg::WORD_W-1:0]   frame_word,
    output logic                          is_header,
    output logic                          frame_end
);

    localparam int SPAN_W = azse_pkg::POS_W + 1;

    logic                           hdr_sent_reg;
    logic                           hdr_sent_next;
    logic                           word_valid_reg;
    logic                           word_valid_next;
    logic [azse_pkg::WORD_W-1:0]    frame_word_reg;
    logic                           is_header_reg;
    logic                           frame_end_reg;
    logic                           load;
    logic                           emit_hdr;
    logic [azse_pkg::WORD_W-1:0]    hdr_word;
    logic [azse_pkg::WORD_W-1:0]    sub_word;
    logic [azse_pkg::DATA_W-1:0]    win;
    logic [azse_pkg::DATA_W-1:0]    body;
    logic [azse_pkg::DATA_W-1:0]    marker_word;
    logic [SPAN_W-1:0]              span;
    logic [SPAN_W-1:0]              start;
    logic [SPAN_W-1:0]              shift;
    logic [azse_pkg::RUN_CNT_W-1:0] final_idx;
    logic [azse_pkg::RUN_LEN-1:0]   marker;

    // The output register takes a new word when empty or being emptied.
    assign load     = head_valid && (!word_valid_reg || !word_stall);
    assign emit_hdr = head_item.first && !hdr_sent_reg;
    assign pop      = load && !emit_hdr;

    // Header: sixteen zeros, the lead bits, C4, C5 and the two M bits.
    assign hdr_word = azse_pkg::WORD_W'({azse_pkg::HDR_LEAD, head_item.c4,
                                         head_item.c5, head_item.m});

    // Subframe body. Everything up to the end of the last run moves eight
    // bits later, and each marker goes where the previous run ended.
    always_comb
    begin
        final_idx   = head_item.run_count - 1'b1;
        span        = {1'b0, head_item.runs[final_idx[1:0]]} + SPAN_W'(azse_pkg::RUN_LEN);
        win         = ~({azse_pkg::DATA_W{1'b1}} >> span);
        body        = (head_item.data & ~win) | ((head_item.data & win) >> azse_pkg::RUN_LEN);
        start       = '0;
        shift       = '0;
        marker      = '0;
        marker_word = '0;
        for (int k = 0; k < azse_pkg::MAX_RUNS; k++)
        begin
            if (azse_pkg::RUN_CNT_W'(k) < head_item.run_count)
            begin
                marker      = {1'b1, (azse_pkg::RUN_CNT_W'(k) == final_idx),
                               head_item.runs[k] + 1'b1, 1'b1};
                shift       = SPAN_W'(azse_pkg::DATA_W - azse_pkg::RUN_LEN) - start;
                marker_word = azse_pkg::DATA_W'(marker) << shift;
                body        = body | marker_word;
                start       = {1'b0, head_item.runs[k]} + SPAN_W'(azse_pkg::RUN_LEN);
            end
        end
        if (head_item.run_count == '0)
        begin
            sub_word = {1'b1, head_item.data};
        end
        else
        begin
            sub_word = {1'b0, body};
        end
    end

    // Control: header phase flag and output valid.
    always_comb
    begin
        hdr_sent_next   = hdr_sent_reg;
        word_valid_next = word_valid_reg;
        if (load)
        begin
            hdr_sent_next   = emit_hdr;
            word_valid_next = 1'b1;
        end
        else if (!word_stall)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_sent_reg   <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_sent_reg   <= hdr_sent_next;
            word_valid_reg <= word_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_word_reg <= emit_hdr ? hdr_word : sub_word;
            is_header_reg  <= emit_hdr;
            frame_end_reg  <= !emit_hdr && head_item.last;
        end
    end

    assign word_valid = word_valid_reg;
    assign frame_word = frame_word_reg;
    assign is_header  = is_header_reg;
    assign frame_end  = frame_end_reg;

endmodule

@@ src/atrau_zero_sequence_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// Zero-sequence substituting frame encoder
// Encodes 36-bit subframes into 37-bit words and adds a frame header.
// ----------------------------------------------------------------------------
// Usage notes.
// The subframe channel (subframe_valid / subframe_stall) takes one 36-bit
// subframe per item, with the M, C4 and C5 bits used on the first subframe
// of each frame of eight. The word channel (word_valid / word_stall) gives
// one output item per cycle at most: the 24-bit header, marked by is_header,
// ahead of the first subframe of a frame, and one 37-bit word per subframe.
// Zero runs are found in the cycle an item is accepted; the item then waits
// in a short queue until the output stage builds its word.
// A subframe word passes through the queue and then the output register,
// after the header word when a frame starts. The input takes one item per cycle while the queue
// has room; the single output register carries nine words for every eight
// subframes, so a full frame occupies nine output words.
// When the receiver stalls, the output word holds and the queue fills; once
// it is full, subframe_stall rises.
// Reset clears the queue, the output valid and the subframe counter, so the
// first subframe after reset starts a new frame.
// ----------------------------------------------------------------------------
module atrau_zero_sequence_frame_encoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          subframe_valid,
    output logic                          subframe_stall,
    input  logic [azse_pkg::DATA_W-1:0]   data_bits,
    input  logic [1:0]                    m_bits,
    input  logic                          c4_bit,
    input  logic                          c5_bit,
    output logic                          word_valid,
    input  logic                          word_stall,
    output logic [azse_pkg::WORD_W-1:0]   frame_word,
    output logic                          is_header,
    output logic                          frame_end
);

    logic            q_full;
    logic            push;
    logic            pop;
    logic            head_valid;
    azse_pkg::item_t push_item;
    azse_pkg::item_t head_item;

    // Acceptance and run detection.
    azse_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_bits      (data_bits),
        .m_bits         (m_bits),
        .c4_bit         (c4_bit),
        .c5_bit         (c5_bit),
        .subframe_valid (subframe_valid),
        .subframe_stall (subframe_stall),
        .q_full         (q_full),
        .push           (push),
        .push_item      (push_item)
    );

    // Decoupling queue.
    azse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Word assembly and output register.
    azse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .frame_word (frame_word),
        .is_header  (is_header),
        .frame_end  (frame_end)
    );

`ifndef SYNTHESIS
    // A header word carries nothing above its lead bits and never ends a frame.
    a_header_form: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && is_header) |->
            (frame_word[36:8] == '0 && frame_word[7:4] == azse_pkg::HDR_LEAD && !frame_end))
        else $error("header word malformed");

    // A taken header is followed at once by its subframe word.
    a_header_then_body: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !word_stall && is_header) |=> (word_valid && !is_header))
        else $error("header not followed by subframe word");

    // An encoded subframe with runs opens with a marker, whose first bit is one.
    a_marker_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !is_header && !frame_word[36]) |-> frame_word[35])
        else $error("encoded subframe does not open with a marker");
`endif

endmodule

@@ verif/azse_word_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zero-sequence frame encoder word checker
// Watches the subframe and word channels of the encoder, works out the words
// that each accepted subframe must produce and compares every accepted output
// item with the oldest outstanding word, field by field.
// ----------------------------------------------------------------------------
module azse_word_checker
    import azse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                subframe_valid,
    input  logic                subframe_stall,
    input  logic [DATA_W-1:0]   data_bits,
    input  logic [1:0]          m_bits,
    input  logic                c4_bit,
    input  logic                c5_bit,
    input  logic                word_valid,
    input  logic                word_stall,
    input  logic [WORD_W-1:0]   frame_word,
    input  logic                is_header,
    input  logic                frame_end,
    output int                  pending,
    output int                  fail_count
);

    // One word the encoder owes us.
    typedef struct {
        logic [WORD_W-1:0] word;
        logic              header;
        logic              last;
    } owed_word_t;

    owed_word_t             owed_words[$];
    logic [SUB_IDX_W-1:0]   sub_pos;
    int                     mismatches;

    // The 24-bit header, right-aligned: sixteen zeros, the lead bits, C4, C5, M.
    function automatic logic [WORD_W-1:0] frame_header_word(input logic [1:0] m,
                                                            input logic c4,
                                                            input logic c5);
        logic [WORD_W-1:0] hdr;
        hdr = '0;
        hdr[7:0] = {HDR_LEAD, c4, c5, m};
        return hdr;
    endfunction

    // Substitutes up to four zero runs in a subframe by marker bytes.
    function automatic logic [WORD_W-1:0] encode_subframe_word(input logic [DATA_W-1:0] d);
        int          run_at[MAX_RUNS];
        int          runs;
        int          scan;
        int          taken;
        logic [63:0] acc;
        logic [4:0]  pos1;
        runs = 0;
        scan = 0;
        acc  = '0;
        // Greedy search: a run found skips its eight bits.
        while (scan <= LAST_RUN_START && runs < MAX_RUNS)
        begin
            if (d[DATA_W-1-scan -: RUN_LEN] == '0)
            begin
                run_at[runs] = scan;
                runs++;
                scan += RUN_LEN;
            end
            else
                scan++;
        end
        if (runs == 0)
            return {1'b1, d};
        // Each marker is followed by the data bits that preceded its run.
        taken = 0;
        for (int n = 0; n < runs; n++)
        begin
            pos1 = 5'(run_at[n] + 1);
            acc  = {acc[55:0], 1'b1, (n == runs - 1), pos1, 1'b1};
            for (int k = taken; k < run_at[n]; k++)
                acc = {acc[62:0], d[DATA_W-1-k]};
            taken = run_at[n] + RUN_LEN;
        end
        for (int k = taken; k < DATA_W; k++)
            acc = {acc[62:0], d[DATA_W-1-k]};
        return acc[WORD_W-1:0];
    endfunction

    // Compare accepted words, then add the words owed for an accepted subframe.
    always @(posedge clk or negedge rst_n)
    begin : watch
        owed_word_t want;
        owed_word_t hdr_rec;
        owed_word_t sub_rec;
        if (!rst_n)
        begin
            owed_words.delete();
            sub_pos    = FIRST_SUB;
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("unexpected item: frame_word %h is_header %b frame_end %b",
                           frame_word, is_header, frame_end);
                    mismatches++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (frame_word !== want.word)
                    begin
                        $error("frame_word: expected %h, got %h", want.word, frame_word);
                        mismatches++;
                    end
                    if (is_header !== want.header)
                    begin
                        $error("is_header: expected %b, got %b", want.header, is_header);
                        mismatches++;
                    end
                    if (frame_end !== want.last)
                    begin
                        $error("frame_end: expected %b, got %b", want.last, frame_end);
                        mismatches++;
                    end
                end
            end
            if (subframe_valid && !subframe_stall)
            begin
                if (sub_pos == FIRST_SUB)
                begin
                    hdr_rec.word   = frame_header_word(m_bits, c4_bit, c5_bit);
                    hdr_rec.header = 1'b1;
                    hdr_rec.last   = 1'b0;
                    owed_words.push_back(hdr_rec);
                end
                sub_rec.word   = encode_subframe_word(data_bits);
                sub_rec.header = 1'b0;
                sub_rec.last   = (sub_pos == LAST_SUB);
                owed_words.push_back(sub_rec);
                sub_pos = sub_pos + 1'b1;
            end
            pending    <= owed_words.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zero-sequence frame encoder testbench
// Sends directed and random subframes in bursts while the receiver stalls on
// a pattern of its own; the word checker beside the encoder predicts and
// compares every output item, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    import azse_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 550;
    localparam int TAIL_CYCLES    = 20;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                subframe_valid;
    logic                subframe_stall;
    logic [DATA_W-1:0]   data_bits;
    logic [1:0]          m_bits;
    logic                c4_bit;
    logic                c5_bit;
    logic                word_valid;
    logic                word_stall = 1'b0;
    logic [WORD_W-1:0]   frame_word;
    logic                is_header;
    logic                frame_end;
    int                  pending;
    int                  fail_count;
    int                  burst_left;
    int                  idle_cycles = 0;
    int                  stall_count = 0;
    int                  stall_mode = 0;

    // Clock with a period of 8 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    atrau_zero_sequence_frame_encoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .subframe_valid (subframe_valid),
        .subframe_stall (subframe_stall),
        .data_bits      (data_bits),
        .m_bits         (m_bits),
        .c4_bit         (c4_bit),
        .c5_bit         (c5_bit),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .frame_word     (frame_word),
        .is_header      (is_header),
        .frame_end      (frame_end)
    );

    azse_word_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .subframe_valid (subframe_valid),
        .subframe_stall (subframe_stall),
        .data_bits      (data_bits),
        .m_bits         (m_bits),
        .c4_bit         (c4_bit),
        .c5_bit         (c5_bit),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .frame_word     (frame_word),
        .is_header      (is_header),
        .frame_end      (frame_end),
        .pending        (pending),
        .fail_count     (fail_count)
    );

    // Receiver stall pattern: a new mode is picked periodically, from no
    // stalls at all through light and heavy random stalls to a periodic block.
    always @(posedge clk)
    begin
        stall_count <= stall_count + 1;
        if (stall_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       word_stall <= 1'b0;
            1:       word_stall <= ($urandom_range(0, 3) == 0);
            2:       word_stall <= ($urandom_range(0, 3) != 0);
            default: word_stall <= (stall_count % 32 < 12);
        endcase
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (subframe_valid && !subframe_stall) || (word_valid && !word_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Clears the bits at first-bit positions pos .. pos+len-1.
    function automatic logic [DATA_W-1:0] clear_run(input logic [DATA_W-1:0] d,
                                                    input int pos, input int len);
        for (int k = pos; k < pos + len && k < DATA_W; k++)
            d[DATA_W-1-k] = 1'b0;
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] random_data();
        return {4'($urandom_range(0, 15)), 32'($urandom)};
    endfunction

    // Random subframe, mostly with zero runs planted so that substitution is hit.
    function automatic logic [DATA_W-1:0] random_subframe();
        logic [DATA_W-1:0] d;
        int                sel;
        int                runs;
        sel = $urandom_range(0, 9);
        d   = random_data();
        if (sel >= 3 && sel <= 7)
        begin
            runs = $urandom_range(1, 4);
            for (int n = 0; n < runs; n++)
                d = clear_run(d, $urandom_range(0, 31), $urandom_range(6, 12));
        end
        else if (sel == 8)
        begin
            d = '0;
            runs = $urandom_range(1, 3);
            for (int n = 0; n < runs; n++)
                d[$urandom_range(0, DATA_W - 1)] = 1'b1;
        end
        else if (sel == 9)
        begin
            case ($urandom_range(0, 2))
                0:       d = '0;
                1:       d = '1;
                default: d = clear_run('1, $urandom_range(0, 35), $urandom_range(1, 10));
            endcase
        end
        return d;
    endfunction

    // Sends one subframe; the sender works in bursts with random gaps between.
    task automatic send_subframe(input logic [DATA_W-1:0] d, input logic [1:0] m,
                                 input logic c4, input logic c5);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            subframe_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // Now and then a long burst, so that stretches pass with no gaps.
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(1, 16);
        end
        subframe_valid <= 1'b1;
        data_bits      <= d;
        m_bits         <= m;
        c4_bit         <= c4;
        c5_bit         <= c5;
        @(posedge clk);
        while (subframe_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // Holds the sender back until every owed word has come out.
    task automatic wait_drained();
        subframe_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [DATA_W-1:0] directed[24];
        logic [1:0]        hdr_m[3];
        logic              hdr_c4[3];
        logic              hdr_c5[3];
        logic [DATA_W-1:0] d;

        rst_n          = 1'b0;
        subframe_valid = 1'b0;
        data_bits      = '0;
        m_bits         = '0;
        c4_bit         = 1'b0;
        c5_bit         = 1'b0;
        burst_left     = 0;

        // Directed subframes: extremes, runs at the edges of the search range,
        // overlapping and adjacent runs, the most runs, and near misses.
        directed[0]  = '0;
        directed[1]  = '1;
        directed[2]  = clear_run('1, 0, 8);
        directed[3]  = clear_run('1, 28, 8);
        directed[4]  = clear_run('1, 27, 8);
        directed[5]  = clear_run('1, 29, 7);
        directed[6]  = clear_run('1, 10, 7);
        directed[7]  = clear_run('1, 5, 9);
        directed[8]  = clear_run('1, 5, 16);
        directed[9]  = clear_run(clear_run(clear_run(clear_run('1, 0, 8), 9, 8), 18, 8), 27, 8);
        directed[10] = 36'hAAAAAAAAA;
        directed[11] = 36'h555555555;
        directed[12] = clear_run(clear_run('1, 1, 8), 20, 8);
        directed[13] = 36'h800000000;
        directed[14] = 36'h000000001;
        directed[15] = clear_run('1, 14, 12);
        for (int i = 16; i < 24; i++)
            directed[i] = clear_run(random_data(), $urandom_range(0, 28), 8);

        // Header fields of the three directed frames; the others are ignored.
        hdr_m  = '{2'd0, 2'd3, 2'd1};
        hdr_c4 = '{1'b0, 1'b1, 1'b0};
        hdr_c5 = '{1'b1, 1'b0, 1'b1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 24; i++)
        begin
            if (i % 8 == 0)
                send_subframe(directed[i], hdr_m[i/8], hdr_c4[i/8], hdr_c5[i/8]);
            else
                send_subframe(directed[i], 2'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            d = random_subframe();
            send_subframe(d, 2'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        // Let the last words out, then a short tail for anything stray.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/azse_pkg.sv
src/azse_front.sv
src/azse_queue.sv
src/azse_back.sv
src/atrau_zero_sequence_frame_encoder.sv
verif/azse_word_checker.sv
verif/testbench.sv
